// ===== hdl/ddta_pkg.sv =====
package ddta_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned NoiseW   = 16;
  localparam int unsigned GainW    = 24;
  localparam int unsigned BoundW   = 31;
  localparam int unsigned CountW   = 16;
  localparam int unsigned TimeW    = 32;

  localparam logic [BoundW-1:0] BoundaryRst = 31'd65536;

  typedef logic signed [31:0] q16_t;
  typedef logic [TimeW-1:0]   time_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DRIFT      = 3'd0,
    CFG_POST_DRIFT = 3'd1,
    CFG_NOISE_GAIN = 3'd2,
    CFG_BOUNDARY   = 3'd3,
    CFG_START      = 3'd4,
    CFG_POST_STEPS = 3'd5,
    CFG_NDT_TICKS  = 3'd6
  } cfg_idx_e;

endpackage

// ===== hdl/ddta_if.sv =====
interface ddta_noise_if import ddta_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [NoiseW-1:0] noise_sample;

  modport source(output valid, output noise_sample, input ready);
  modport sink(input valid, input noise_sample, output ready);
endinterface

interface ddta_result_if import ddta_pkg::*; ();
  logic  valid;
  logic  ready;
  time_t decision_time;
  logic  response_upper;
  logic  correct;
  q16_t  final_evidence;
  time_t final_time;
  q16_t  confidence;

  modport source(output valid, output decision_time, output response_upper, output correct,
                 output final_evidence, output final_time, output confidence, input ready);
  modport sink(input valid, input decision_time, input response_upper, input correct,
               input final_evidence, input final_time, input confidence, output ready);
endinterface

// ===== hdl/drift_diffusion_trial_accumulator.sv =====
// A noise request is scaled into the scaled-noise register nz_q when taken, stage B
// then updates the evidence from it, and a finished trial goes to the result register.
// Throughput: one noise request per cycle unless a trial end meets a stalled result;
// nz_q decouples input from a stalled result; one request is taken while it waits.
// Reset (rst_ni low, async): registers take their documented values, evidence is zero.
module drift_diffusion_trial_accumulator import ddta_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  ddta_noise_if.sink          noise_i,
  ddta_result_if.source       result_o
);

  // configuration
  q16_t              drift_q;
  q16_t              post_drift_q;
  logic [GainW-1:0]  gain_q;
  logic [BoundW-1:0] bound_q;
  q16_t              start_q;
  logic [CountW-1:0] post_steps_q;
  logic [CountW-1:0] ndt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drift_q      <= '0;
      post_drift_q <= '0;
      gain_q       <= '0;
      bound_q      <= BoundaryRst;
      start_q      <= '0;
      post_steps_q <= '0;
      ndt_q        <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DRIFT:      drift_q      <= cfg_wdata_i;
        CFG_POST_DRIFT: post_drift_q <= cfg_wdata_i;
        CFG_NOISE_GAIN: gain_q       <= cfg_wdata_i[GainW-1:0];
        CFG_BOUNDARY:   bound_q      <= cfg_wdata_i[BoundW-1:0];
        CFG_START:      start_q      <= cfg_wdata_i;
        CFG_POST_STEPS: post_steps_q <= cfg_wdata_i[CountW-1:0];
        CFG_NDT_TICKS:  ndt_q        <= cfg_wdata_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // stage A: noise scaling
  logic               a_fire;
  logic               b_fire;
  logic               nz_v_q;
  logic signed [27:0] nz_q;
  logic signed [40:0] prod_w;

  assign noise_i.ready = !nz_v_q || b_fire;
  assign a_fire        = noise_i.valid && noise_i.ready;
  assign prod_w        = $signed({1'b0, gain_q}) * noise_i.noise_sample;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nz_v_q <= 1'b0;
    end else if (a_fire) begin
      nz_v_q <= 1'b1;
    end else if (b_fire) begin
      nz_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_fire) begin
      nz_q <= prod_w[39:12];
    end
  end

  // stage B: evidence update
  q16_t              ev_q;
  time_t             tick_q;
  logic [CountW-1:0] post_q;
  logic              post_phase_q;
  logic              resp_q;
  logic              corr_q;

  q16_t              step_w;
  logic [33:0]       sum_w;
  q16_t              sat_w;
  q16_t              bound_s;
  q16_t              neg_bound;
  logic              hit_up;
  logic              hit_lo;
  time_t             tick_inc;
  logic [CountW-1:0] post_inc;

  q16_t              ev_n;
  time_t             tick_n;
  logic [CountW-1:0] post_n;
  logic              phase_n;
  logic              resp_n;
  logic              corr_n;
  logic              emit_w;

  logic              out_v_q;
  logic              out_free;

  assign step_w    = post_phase_q ? post_drift_q : drift_q;
  assign sum_w     = {{2{ev_q[31]}}, ev_q} + {{2{step_w[31]}}, step_w} + {{6{nz_q[27]}}, nz_q};
  assign bound_s   = $signed({1'b0, bound_q});
  assign neg_bound = -bound_s;
  assign tick_inc  = (&tick_q) ? tick_q : tick_q + 32'd1;
  assign post_inc  = (&post_q) ? post_q : post_q + 16'd1;

  always_comb begin
    if (sum_w[33:31] == 3'b000 || sum_w[33:31] == 3'b111) begin
      sat_w = sum_w[31:0];
    end else if (sum_w[33]) begin
      sat_w = 32'sh8000_0000;
    end else begin
      sat_w = 32'sh7fff_ffff;
    end
  end

  assign hit_up = !post_phase_q && (sat_w >= bound_s);
  assign hit_lo = !post_phase_q && !hit_up && (sat_w <= neg_bound);

  always_comb begin
    ev_n    = sat_w;
    tick_n  = tick_q;
    post_n  = post_q;
    phase_n = post_phase_q;
    resp_n  = resp_q;
    corr_n  = corr_q;
    emit_w  = 1'b0;
    if (post_phase_q) begin
      post_n = post_inc;
      emit_w = post_inc >= post_steps_q;
    end else begin
      tick_n = tick_inc;
      if (hit_up) begin
        ev_n    = bound_s;
        resp_n  = 1'b1;
        corr_n  = !drift_q[31] && (drift_q != '0);
        phase_n = 1'b1;
        post_n  = '0;
        emit_w  = post_steps_q == '0;
      end else if (hit_lo) begin
        ev_n    = neg_bound;
        resp_n  = 1'b0;
        corr_n  = drift_q[31];
        phase_n = 1'b1;
        post_n  = '0;
        emit_w  = post_steps_q == '0;
      end
    end
  end

  assign out_free = !out_v_q || result_o.ready;
  assign b_fire   = nz_v_q && (!emit_w || out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_q         <= '0;
      tick_q       <= '0;
      post_q       <= '0;
      post_phase_q <= 1'b0;
      resp_q       <= 1'b0;
      corr_q       <= 1'b0;
    end else if (b_fire) begin
      if (emit_w) begin
        ev_q         <= start_q;
        tick_q       <= '0;
        post_q       <= '0;
        post_phase_q <= 1'b0;
        resp_q       <= 1'b0;
        corr_q       <= 1'b0;
      end else begin
        ev_q         <= ev_n;
        tick_q       <= tick_n;
        post_q       <= post_n;
        post_phase_q <= phase_n;
        resp_q       <= resp_n;
        corr_q       <= corr_n;
      end
    end
  end

  // result register
  q16_t              out_ev_q;
  time_t             out_tick_q;
  logic [CountW-1:0] out_post_q;
  logic              out_resp_q;
  logic              out_corr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (b_fire && emit_w) begin
      out_v_q <= 1'b1;
    end else if (result_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_fire && emit_w) begin
      out_ev_q   <= ev_n;
      out_tick_q <= tick_n;
      out_post_q <= post_n;
      out_resp_q <= resp_n;
      out_corr_q <= corr_n;
    end
  end

  // result formatting; the user must keep configuration stable while a result is pending (not enforced here)
  logic [TimeW:0] dt_sum;
  logic [TimeW:0] tp_sum;
  time_t          tp_sat;
  logic [TimeW:0] ft_sum;
  logic [32:0]    conf_diff;

  assign dt_sum    = {1'b0, out_tick_q} + {17'b0, ndt_q};
  assign tp_sum    = {1'b0, out_tick_q} + {17'b0, out_post_q};
  assign tp_sat    = tp_sum[TimeW] ? '1 : tp_sum[TimeW-1:0];
  assign ft_sum    = {1'b0, tp_sat} + {17'b0, ndt_q};
  assign conf_diff = out_resp_q ? {out_ev_q[31], out_ev_q} - {2'b00, bound_q}
                                : {2'b00, bound_q} - {out_ev_q[31], out_ev_q};

  assign result_o.valid          = out_v_q;
  assign result_o.decision_time  = dt_sum[TimeW] ? '1 : dt_sum[TimeW-1:0];
  assign result_o.final_time     = ft_sum[TimeW] ? '1 : ft_sum[TimeW-1:0];
  assign result_o.response_upper = out_resp_q;
  assign result_o.correct        = out_corr_q;
  assign result_o.final_evidence = out_ev_q;

  always_comb begin
    if (conf_diff[32] == conf_diff[31]) begin
      result_o.confidence = conf_diff[31:0];
    end else if (conf_diff[32]) begin
      result_o.confidence = 32'sh8000_0000;
    end else begin
      result_o.confidence = 32'sh7fff_ffff;
    end
  end

  // checks
  a_restart_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_fire && emit_w) |=> (tick_q == '0 && post_q == '0 && !post_phase_q))
    else $error("trial state not restarted after result");

  a_post_count_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (post_q != '0) |-> post_phase_q)
    else $error("post count running outside post phase");

  a_post_phase_ticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    post_phase_q |-> (tick_q != '0))
    else $error("post phase entered without a decision tick");

  a_no_result_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !result_o.ready) |-> !(b_fire && emit_w))
    else $error("pending result overwritten");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import ddta_pkg::*;

  localparam int QuietLimit = 2000;

  typedef struct {
    time_t decision_time;
    logic  response_upper;
    logic  correct;
    q16_t  final_evidence;
    time_t final_time;
    q16_t  confidence;
  } trial_rec_t;

  class trial_scoreboard;
    q16_t              drift;
    q16_t              post_drift;
    logic [GainW-1:0]  gain;
    logic [BoundW-1:0] bound;
    q16_t              start;
    logic [CountW-1:0] post_steps;
    logic [CountW-1:0] ndt;

    q16_t              evidence;
    time_t             ticks;
    logic [CountW-1:0] post_cnt;
    bit                in_post;
    bit                resp_up;
    bit                corr;

    trial_rec_t        trial_q[$];
    int                errors;

    function new();
      drift      = '0;
      post_drift = '0;
      gain       = '0;
      bound      = BoundaryRst;
      start      = '0;
      post_steps = '0;
      ndt        = '0;
      errors     = 0;
      restart();
    endfunction

    function void restart();
      evidence = start;
      ticks    = '0;
      post_cnt = '0;
      in_post  = 1'b0;
      resp_up  = 1'b0;
      corr     = 1'b0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CfgDataW-1:0] v);
      case (idx)
        CFG_DRIFT:      drift      = q16_t'(v);
        CFG_POST_DRIFT: post_drift = q16_t'(v);
        CFG_NOISE_GAIN: gain       = v[GainW-1:0];
        CFG_BOUNDARY:   bound      = v[BoundW-1:0];
        CFG_START:      start      = q16_t'(v);
        CFG_POST_STEPS: post_steps = v[CountW-1:0];
        CFG_NDT_TICKS:  ndt        = v[CountW-1:0];
        default: ;
      endcase
    endfunction

    function q16_t clip32(longint v);
      if (v > 64'sd2147483647) return q16_t'(32'h7FFF_FFFF);
      if (v < -64'sd2147483648) return q16_t'(32'h8000_0000);
      return q16_t'(v[31:0]);
    endfunction

    function time_t add_sat(time_t a, time_t b);
      longint s;
      s = longint'(a) + longint'(b);
      return (s > 64'sd4294967295) ? '1 : s[31:0];
    endfunction

    function void close_trial();
      trial_rec_t r;
      longint     conf;
      conf = resp_up ? longint'(evidence) - longint'(bound)
                     : longint'(bound) - longint'(evidence);
      r.decision_time  = add_sat(ticks, time_t'(ndt));
      r.response_upper = resp_up;
      r.correct        = corr;
      r.final_evidence = evidence;
      r.final_time     = add_sat(add_sat(ticks, time_t'(post_cnt)), time_t'(ndt));
      r.confidence     = clip32(conf);
      trial_q.push_back(r);
      restart();
    endfunction

    function void note_noise(logic signed [NoiseW-1:0] n);
      longint nz;
      longint e;
      longint b;
      nz = (longint'(gain) * longint'(n)) >>> 12;
      if (!in_post) begin
        ticks = add_sat(ticks, 32'd1);
        e = clip32(longint'(evidence) + longint'(drift) + nz);
        b = longint'(bound);
        if (e >= b) begin
          evidence = q16_t'(b);
          resp_up  = 1'b1;
          corr     = drift > 0;
        end else if (e <= -b) begin
          evidence = q16_t'(-b);
          resp_up  = 1'b0;
          corr     = drift < 0;
        end else begin
          evidence = q16_t'(e);
          return;
        end
        in_post  = 1'b1;
        post_cnt = '0;
        if (post_steps == 0) close_trial();
        return;
      end
      if (post_cnt != '1) post_cnt++;
      evidence = clip32(longint'(evidence) + longint'(post_drift) + nz);
      if (post_cnt >= post_steps) close_trial();
    endfunction

    function void mismatch(string field, longint got, longint exp_v);
      errors++;
      if (errors <= 10)
        $display("mismatch %s: expected %0d got %0d", field, exp_v, got);
    endfunction

    function void check_result(trial_rec_t got);
      trial_rec_t x;
      if (trial_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected trial result, decision_time %0d",
                                   got.decision_time);
        return;
      end
      x = trial_q.pop_front();
      if (got.decision_time !== x.decision_time)
        mismatch("decision_time", got.decision_time, x.decision_time);
      if (got.response_upper !== x.response_upper)
        mismatch("response_upper", got.response_upper, x.response_upper);
      if (got.correct !== x.correct)
        mismatch("correct", got.correct, x.correct);
      if (got.final_evidence !== x.final_evidence)
        mismatch("final_evidence", got.final_evidence, x.final_evidence);
      if (got.final_time !== x.final_time)
        mismatch("final_time", got.final_time, x.final_time);
      if (got.confidence !== x.confidence)
        mismatch("confidence", got.confidence, x.confidence);
    endfunction

    function int pending();
      return trial_q.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  ddta_noise_if  noise_ch();
  ddta_result_if result_ch();

  drift_diffusion_trial_accumulator uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .noise_i    (noise_ch),
    .result_o   (result_ch)
  );

  trial_scoreboard sb = new();
  bit idle_en;
  bit stall_en;
  int quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_en && $urandom_range(0, 7) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk_i);
      end
      result_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    trial_rec_t got;
    bool_accept: begin
      if (rst_ni) begin
        if (noise_ch.valid && noise_ch.ready) sb.note_noise(noise_ch.noise_sample);
        if (result_ch.valid && result_ch.ready) begin
          got.decision_time  = result_ch.decision_time;
          got.response_upper = result_ch.response_upper;
          got.correct        = result_ch.correct;
          got.final_evidence = result_ch.final_evidence;
          got.final_time     = result_ch.final_time;
          got.confidence     = result_ch.confidence;
          sb.check_result(got);
        end
        if ((noise_ch.valid && noise_ch.ready) || (result_ch.valid && result_ch.ready))
          quiet_cycles = 0;
        else
          quiet_cycles++;
        if (quiet_cycles >= QuietLimit) begin
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    sb.set_reg(idx, v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_noise(input logic signed [NoiseW-1:0] n);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      noise_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    noise_ch.valid        <= 1'b1;
    noise_ch.noise_sample <= n;
    @(posedge clk_i);
    while (!noise_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // drop the request line and let trials in flight drain
  task automatic pause_feed();
    noise_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic run_random(input int count);
    repeat (count) send_noise(NoiseW'($urandom));
    pause_feed();
  endtask

  task automatic random_setup(input bit wild);
    logic [CfgDataW-1:0] bnd;
    if (wild) begin
      bnd = ($urandom_range(0, 3) == 0) ? 32'h7FFF_FFFF : ($urandom & 32'h7FFF_FFFF);
      write_reg(CFG_DRIFT, $urandom);
      write_reg(CFG_POST_DRIFT, $urandom);
      write_reg(CFG_NOISE_GAIN, $urandom & 32'h00FF_FFFF);
      write_reg(CFG_START, $urandom);
      write_reg(CFG_POST_STEPS, $urandom_range(0, 20));
    end else begin
      bnd = $urandom_range(16384, 131072);
      write_reg(CFG_DRIFT, $urandom_range(0, 16384) - 8192);
      write_reg(CFG_POST_DRIFT, $urandom_range(0, 131072) - 65536);
      write_reg(CFG_NOISE_GAIN, $urandom_range(16384, 131072));
      write_reg(CFG_START, $urandom_range(0, 2 * bnd) - bnd);
      write_reg(CFG_POST_STEPS, $urandom_range(0, 6));
    end
    write_reg(CFG_BOUNDARY, bnd);
    write_reg(CFG_NDT_TICKS, $urandom_range(0, 65535));
  endtask

  initial begin
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_idx_i             = CFG_DRIFT;
    cfg_wdata_i           = '0;
    noise_ch.valid        = 1'b0;
    noise_ch.noise_sample = '0;
    idle_en               = 1'b1;
    stall_en              = 1'b1;
    quiet_cycles          = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset values: no drift, no gain, evidence parks at zero
    send_noise(16'sh7FFF);
    send_noise(16'sh8000);
    pause_feed();

    write_reg(CFG_DRIFT, 32'h0000_8000);
    write_reg(CFG_NDT_TICKS, 32'h0000_FFFF);
    send_noise(16'sh0000);
    send_noise(16'sh0000);
    pause_feed();

    // zero bound: zero sum goes upper, zero drift is never correct
    write_reg(CFG_BOUNDARY, 32'h0);
    write_reg(CFG_DRIFT, 32'h0);
    send_noise(16'sh0000);
    pause_feed();
    write_reg(CFG_DRIFT, 32'hFFFF_FFFF);
    send_noise(16'sh0001);
    pause_feed();

    // full-scale settings, evidence and confidence saturate
    write_reg(CFG_BOUNDARY, 32'h7FFF_FFFF);
    write_reg(CFG_DRIFT, 32'h7FFF_FFFF);
    write_reg(CFG_NOISE_GAIN, 32'h00FF_FFFF);
    write_reg(CFG_POST_DRIFT, 32'h8000_0000);
    write_reg(CFG_POST_STEPS, 32'd2);
    write_reg(CFG_START, 32'h7FFF_FFFF);
    send_noise(16'sh7FFF);
    send_noise(16'sh8000);
    send_noise(16'sh8000);
    send_noise(16'sh7FFF);
    send_noise(16'shFFFF);
    send_noise(16'sh0000);
    pause_feed();

    // start written mid-trial, next trial starts past the lower bound
    write_reg(CFG_BOUNDARY, 32'h0001_0000);
    write_reg(CFG_START, 32'h8000_0000);
    write_reg(CFG_DRIFT, 32'h0);
    write_reg(CFG_NOISE_GAIN, 32'h0);
    write_reg(CFG_POST_STEPS, 32'd3);
    repeat (6) send_noise(NoiseW'($urandom));
    pause_feed();
    // shorten the post phase while it runs
    write_reg(CFG_POST_STEPS, 32'd1);
    send_noise(NoiseW'($urandom));
    pause_feed();

    for (int p = 0; p < 10; p++) begin
      idle_en  = $urandom_range(0, 3) != 0;
      stall_en = $urandom_range(0, 3) != 0;
      random_setup(p == 3 || p == 7);
      run_random(30);
    end

    // long post phase
    idle_en  = 1'b1;
    stall_en = 1'b1;
    random_setup(1'b0);
    write_reg(CFG_BOUNDARY, 32'h0);
    write_reg(CFG_POST_STEPS, 32'd60);
    run_random(64);

    idle_en  = 1'b0;
    stall_en = 1'b0;
    random_setup(1'b0);
    run_random(60);

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/ddta_pkg.sv
hdl/ddta_if.sv
hdl/drift_diffusion_trial_accumulator.sv
tb/tb.sv
